FILE: hw/rtl/sbo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbo_pkg: shared types and codes of the select-before-operate controller
// Transaction structs, command/action/status codes, sequencer states and
// the per-point mask lookup used by the controller and its point evaluator.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int SBO_NUM_POINTS   = 16;
    localparam int SBO_TIMEOUT_BITS = 8;
    localparam int MASK_W           = 16;
    localparam int REQ_ADDR_W       = 32;

    localparam logic [2:0] CMD_SELECT        = 3'd0;
    localparam logic [2:0] CMD_EXECUTE       = 3'd1;
    localparam logic [2:0] CMD_CANCEL        = 3'd2;
    localparam logic [2:0] CMD_TICK          = 3'd3;
    localparam logic [2:0] CMD_CANCEL_REMOTE = 3'd4;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SELECT  = 2'd1;
    localparam logic [1:0] ACT_EXECUTE = 2'd2;
    localparam logic [1:0] ACT_CANCEL  = 2'd3;

    localparam logic [2:0] STS_OK               = 3'd0;
    localparam logic [2:0] STS_UNKNOWN_POINT    = 3'd1;
    localparam logic [2:0] STS_UNKNOWN_SOURCE   = 3'd2;
    localparam logic [2:0] STS_ALREADY_SELECTED = 3'd3;
    localparam logic [2:0] STS_NOT_SELECTED     = 3'd4;
    localparam logic [2:0] STS_SOURCE_MISMATCH  = 3'd5;
    localparam logic [2:0] STS_ADDRESS_MISMATCH = 3'd6;
    localparam logic [2:0] STS_BAD_COMMAND      = 3'd7;

    localparam logic [2:0] SRC_LAST_KNOWN  = 3'd3;
    localparam logic [1:0] SRC_LAST_REMOTE = 2'd1;

    localparam logic [1:0] REG_POINT_VALID = 2'd0;
    localparam logic [1:0] REG_SELECT_CMD  = 2'd1;
    localparam logic [1:0] REG_CANCEL_CMD  = 2'd2;

    typedef struct packed {
        logic [2:0]            command;
        logic [3:0]            point_index;
        logic [2:0]            source_code;
        logic [REQ_ADDR_W-1:0] requester_address;
        logic [7:0]            timeout_ticks;
    } sbo_in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] action_point;
        logic [2:0] status;
        logic       timed_out;
        logic       last;
    } sbo_out_t;

    typedef struct packed {
        logic valid;
        logic selected;
        logic pending;
        logic select_cmd;
        logic cancel_cmd;
    } sbo_point_t;

    typedef struct packed {
        logic       emit;
        logic       set_flags;
        logic       clr_flags;
        logic       wr_en;
        logic [1:0] action;
        logic [2:0] status;
        logic       timed_out;
    } sbo_eval_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_FLUSH
    } sbo_state_t;

    function automatic logic mask_bit(logic [MASK_W-1:0] mask, logic [6:0] idx);
        return (idx < 7'(MASK_W)) && mask[idx[3:0]];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/select_before_operate_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// select_before_operate_controller: select-before-operate guard
// Per-point select/execute/cancel arbitration with expiry and remote drop.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item and raise start while busy is low; the transaction is taken
//   at that edge and busy stays high until the work on it is done.
//   Select, execute, cancel and bad commands read the point's entry at the
//   accept edge and evaluate it in the next cycle: one result, result_valid
//   high in the cycle after that; busy is low again in that same cycle, so
//   the next command can be taken while the result is shown.
//   Tick and remote cancel walk every point, one per cycle through the
//   shared evaluator and the entry RAM read port, with zero to NUM_POINTS
//   results, the last marked by result.last. Results leave in point order,
//   at most one per cycle; each is held until the next match or the end of
//   the walk, so gaps follow the point pattern. The receiver cannot stall:
//   every result_valid cycle is one transaction. Masks are written on the cfg
//   channel (cfg_ready always high) only while idle, by the user, unenforced.
//   Reset clears all selections and masks; no sweep of the RAM is needed.
// ----------------------------------------------------------------------------
module select_before_operate_controller import sbo_pkg::*; #(
    parameter int NUM_POINTS   = SBO_NUM_POINTS,
    parameter int TIMEOUT_BITS = SBO_TIMEOUT_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sbo_in_t           item,
    output logic                   result_valid,
    output sbo_out_t               result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [MASK_W-1:0] cfg_data
);

    localparam int IDX_W   = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int ENTRY_W = 2 + REQ_ADDR_W + TIMEOUT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

    sbo_state_t              state_reg, state_next;
    sbo_in_t                 item_reg;
    logic [IDX_W-1:0]        cur_idx_reg, cur_idx_next;
    logic [NUM_POINTS-1:0]   sel_reg;
    logic [NUM_POINTS-1:0]   pend_reg;
    logic [MASK_W-1:0]       valid_mask_reg;
    logic [MASK_W-1:0]       select_mask_reg;
    logic [MASK_W-1:0]       cancel_mask_reg;
    sbo_out_t                hold_reg, hold_next;
    logic                    hold_valid_reg, hold_valid_next;
    sbo_out_t                result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    accept;
    logic                    walk_in;
    logic                    in_range_in;
    logic [IDX_W-1:0]        idx_in;
    logic                    eval_on;
    sbo_point_t              point;
    sbo_eval_t               ctl;
    sbo_out_t                new_res;
    logic [ENTRY_W-1:0]      rd_data;
    logic [ENTRY_W-1:0]      wr_data;

    assign busy         = state_reg != ST_IDLE;
    assign accept       = start && !busy;
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign walk_in     = (item.command == CMD_TICK) || (item.command == CMD_CANCEL_REMOTE);
    assign in_range_in = 7'(item.point_index) < 7'(NUM_POINTS);
    assign idx_in      = in_range_in ? IDX_W'(item.point_index) : '0;
    assign eval_on     = (state_reg == ST_EVAL) || (state_reg == ST_WALK);

    assign point.valid      = (7'(item_reg.point_index) < 7'(NUM_POINTS))
                              && mask_bit(valid_mask_reg, 7'(cur_idx_reg));
    assign point.selected   = sel_reg[cur_idx_reg];
    assign point.pending    = pend_reg[cur_idx_reg];
    assign point.select_cmd = mask_bit(select_mask_reg, 7'(cur_idx_reg));
    assign point.cancel_cmd = mask_bit(cancel_mask_reg, 7'(cur_idx_reg));

    sbo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_POINTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (eval_on && ctl.wr_en),
        .wr_addr (cur_idx_reg),
        .wr_data (wr_data),
        .rd_addr (cur_idx_next),
        .rd_data (rd_data)
    );

    sbo_eval #(
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_eval (
        .item    (item_reg),
        .point   (point),
        .entry   (rd_data),
        .ctl     (ctl),
        .wr_data (wr_data)
    );

    always_comb
    begin
        new_res.action       = ctl.action;
        new_res.action_point = 4'(cur_idx_reg);
        new_res.status       = ctl.status;
        new_res.timed_out    = ctl.timed_out;
        new_res.last         = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = walk_in ? ST_WALK : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (cur_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_idx_next      = cur_idx_reg;
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_idx_next    = walk_in ? '0 : idx_in;
                    hold_valid_next = 1'b0;
                end
            end
            ST_EVAL:
            begin
                result_next       = new_res;
                result_next.last  = 1'b1;
                result_valid_next = 1'b1;
            end
            ST_WALK:
            begin
                if (cur_idx_reg != LAST_IDX)
                begin
                    cur_idx_next = IDX_W'(cur_idx_reg + 1'b1);
                end
                if (ctl.emit)
                begin
                    // release the held result once a later one is known
                    if (hold_valid_reg)
                    begin
                        result_next       = hold_reg;
                        result_valid_next = 1'b1;
                    end
                    hold_next       = new_res;
                    hold_valid_next = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    result_next       = hold_reg;
                    result_next.last  = 1'b1;
                    result_valid_next = 1'b1;
                end
                hold_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_idx_reg      <= '0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            sel_reg          <= '0;
            pend_reg         <= '0;
            valid_mask_reg   <= '0;
            select_mask_reg  <= '0;
            cancel_mask_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_idx_reg      <= cur_idx_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            if (eval_on && ctl.set_flags)
            begin
                sel_reg[cur_idx_reg]  <= 1'b1;
                pend_reg[cur_idx_reg] <= 1'b1;
            end
            else if (eval_on && ctl.clr_flags)
            begin
                sel_reg[cur_idx_reg]  <= 1'b0;
                pend_reg[cur_idx_reg] <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_POINT_VALID: valid_mask_reg  <= cfg_data;
                    REG_SELECT_CMD:  select_mask_reg <= cfg_data;
                    REG_CANCEL_CMD:  cancel_mask_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

`ifndef SYNTH
    a_pend_tracks_sel: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == sel_reg)
        else $error("pending flags diverge from selected flags");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result strobe right after final result");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/sbo_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbo_ram: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sbo_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbo_eval: shared point evaluator
// Checks and updates one control point per cycle for every command: guard
// checks, countdown compare and decrement, remote-drop match.
// ----------------------------------------------------------------------------
module sbo_eval import sbo_pkg::*; #(
    parameter int TIMEOUT_BITS = SBO_TIMEOUT_BITS,
    localparam int ENTRY_W = 2 + REQ_ADDR_W + TIMEOUT_BITS
) (
    input  wire sbo_in_t             item,
    input  wire sbo_point_t          point,
    input  wire logic [ENTRY_W-1:0]  entry,
    output sbo_eval_t                ctl,
    output logic      [ENTRY_W-1:0]  wr_data
);

    localparam logic [16:0] CNT_MAX = 17'((1 << TIMEOUT_BITS) - 1);

    logic [1:0]              ent_src;
    logic [REQ_ADDR_W-1:0]   ent_addr;
    logic [TIMEOUT_BITS-1:0] ent_cnt;
    logic [TIMEOUT_BITS-1:0] sat_cnt;
    logic                    expiring;
    logic [1:0]              cancel_act;

    assign ent_src    = entry[ENTRY_W-1 -: 2];
    assign ent_addr   = entry[TIMEOUT_BITS +: REQ_ADDR_W];
    assign ent_cnt    = entry[TIMEOUT_BITS-1:0];
    assign sat_cnt    = (17'(item.timeout_ticks) > CNT_MAX) ? TIMEOUT_BITS'(CNT_MAX)
                                                            : TIMEOUT_BITS'(item.timeout_ticks);
    assign expiring   = 17'(ent_cnt) <= 17'd1;
    assign cancel_act = point.cancel_cmd ? ACT_CANCEL : ACT_NONE;

    always_comb
    begin
        ctl     = '0;
        wr_data = {item.source_code[1:0], item.requester_address, sat_cnt};
        unique case (item.command)
            CMD_SELECT, CMD_EXECUTE, CMD_CANCEL:
            begin
                ctl.emit = 1'b1;
                priority if (!point.valid)
                begin
                    ctl.status = STS_UNKNOWN_POINT;
                end
                else if (item.source_code > SRC_LAST_KNOWN)
                begin
                    ctl.status = STS_UNKNOWN_SOURCE;
                end
                else if (item.command == CMD_SELECT)
                begin
                    if (point.selected)
                    begin
                        ctl.status = STS_ALREADY_SELECTED;
                    end
                    else
                    begin
                        ctl.set_flags = 1'b1;
                        ctl.wr_en     = 1'b1;
                        ctl.action    = point.select_cmd ? ACT_SELECT : ACT_NONE;
                    end
                end
                else if (!point.selected)
                begin
                    ctl.status = STS_NOT_SELECTED;
                end
                else if (ent_src != item.source_code[1:0])
                begin
                    ctl.status = STS_SOURCE_MISMATCH;
                end
                else if (ent_addr != item.requester_address)
                begin
                    ctl.status = STS_ADDRESS_MISMATCH;
                end
                else
                begin
                    ctl.clr_flags = 1'b1;
                    ctl.action    = (item.command == CMD_EXECUTE) ? ACT_EXECUTE : cancel_act;
                end
            end
            CMD_TICK:
            begin
                if (point.pending)
                begin
                    if (expiring)
                    begin
                        ctl.clr_flags = 1'b1;
                        ctl.emit      = 1'b1;
                        ctl.action    = cancel_act;
                        ctl.timed_out = 1'b1;
                    end
                    else
                    begin
                        ctl.wr_en = 1'b1;
                        wr_data   = {ent_src, ent_addr, ent_cnt - TIMEOUT_BITS'(1)};
                    end
                end
            end
            CMD_CANCEL_REMOTE:
            begin
                if (point.selected && (ent_src <= SRC_LAST_REMOTE))
                begin
                    ctl.clr_flags = 1'b1;
                    ctl.emit      = 1'b1;
                    ctl.action    = cancel_act;
                end
            end
            default:
            begin
                ctl.emit   = 1'b1;
                ctl.status = STS_BAD_COMMAND;
            end
        endcase
    end

endmodule
`default_nettype wire
